### hdl/tcb_pkg.sv
// Shared constants, codes and types of the text console buffer.
package tcb_pkg;

    // Default geometry of the buffer.
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_ATTR_BITS = 8;

    // Fixed field widths of the stream words.
    localparam int ACTION_W = 4;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 6;
    localparam int M_TDATA_W = 24;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Action codes.
    localparam action_t ACT_WR_CHAR  = 4'd0;
    localparam action_t ACT_RD_CHAR  = 4'd1;
    localparam action_t ACT_WR_ATTR  = 4'd2;
    localparam action_t ACT_RD_ATTR  = 4'd3;
    localparam action_t ACT_SET_CUR  = 4'd4;
    localparam action_t ACT_PRINT    = 4'd5;
    localparam action_t ACT_NEWLINE  = 4'd6;
    localparam action_t ACT_SET_ATTR = 4'd7;
    localparam action_t ACT_CLEAR    = 4'd8;

    // Status codes.
    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_RANGE   = 2'd1;
    localparam status_t STAT_DROPPED = 2'd2;

    // Value returned by a character read outside the buffer.
    localparam logic [BYTE_W-1:0] CHAR_OUT_OF_RANGE = 8'hFF;

endpackage

### hdl/text_console_buffer_core.sv
// Text-mode character buffer with cursor, current attribute and string printing.
//
//  Channel   Direction  Fields (lowest bit first)
//  s_axis    in         tdata: column, row_index, char_value, attr_value
//                       tuser: action, starts_text, from_cursor
//  m_axis    out        tdata: read_value, cursor_col, cursor_row, status
//
// For every word except a read, the cell write, cursor update and result
// register load all happen at the accepting edge. A character or attribute
// read first loads the registered read port of the cell memories, and the
// result register is loaded from that port in the read state. A clear, and the
// reset itself, sweep both memories one cell per cycle over all COLUMNS*ROWS
// cells (2000 by default), during which no word is accepted. Results wait in an
// output register; a new word is accepted while that register is empty or being drained in the same cycle.
module text_console_buffer_core #(
    parameter int COLUMNS   = tcb_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcb_pkg::DEF_ROWS,
    parameter int ATTR_BITS = tcb_pkg::DEF_ATTR_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_axis_tdata: column[6:0], row_index[11:7], char_value[19:12],
    // attr_value[27:20], zero fill[31:28].
    input  logic [tcb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: action[3:0], starts_text[4], from_cursor[5].
    input  logic [tcb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // m_axis_tdata: read_value[7:0], cursor_col[14:8], cursor_row[19:15],
    // status[21:20], zero fill[23:22].
    output logic [tcb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    import tcb_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int POS_W  = $clog2(CELLS + 1);

    localparam logic [COL_W-1:0]  COL_LIM   = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LIM   = ROW_W'(ROWS);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [POS_W-1:0]  POS_END   = POS_W'(CELLS);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    // Unpacked input word.
    action_t              in_action;
    logic [COL_W-1:0]     in_col;
    logic [ROW_W-1:0]     in_row;
    logic [BYTE_W-1:0]    in_char;
    logic [ATTR_BITS-1:0] in_attr;
    logic                 in_starts;
    logic                 in_fromcur;

    assign in_col     = s_axis_tdata[6:0];
    assign in_row     = s_axis_tdata[11:7];
    assign in_char    = s_axis_tdata[19:12];
    assign in_attr    = s_axis_tdata[20 +: ATTR_BITS];
    assign in_action  = s_axis_tuser[3:0];
    assign in_starts  = s_axis_tuser[4];
    assign in_fromcur = s_axis_tuser[5];

    // Control and state registers.
    logic [1:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic [COL_W-1:0]      cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]      cur_row_reg, cur_row_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [COL_W-1:0]      pcol_reg, pcol_next;
    logic [ROW_W-1:0]      prow_reg, prow_next;
    logic                  abort_reg, abort_next;
    logic [ATTR_BITS-1:0]  attr_reg, attr_next;
    logic                  rd_char_reg, rd_char_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Cell index: a print started from the cursor indexes at the cursor,
    // everything else at the word's column and row.
    logic             use_cursor;
    logic [COL_W-1:0] sel_col;
    logic [ROW_W-1:0] sel_row;
    logic [POS_W-1:0] cell_idx;
    logic             in_ok;

    assign use_cursor = (in_action == ACT_PRINT) && in_starts && in_fromcur;
    assign sel_col    = use_cursor ? cur_col_reg : in_col;
    assign sel_row    = use_cursor ? cur_row_reg : in_row;
    assign cell_idx   = POS_W'(sel_row * COLUMNS) + POS_W'(sel_col);
    assign in_ok      = (in_col < COL_LIM) && (in_row < ROW_LIM);

    // Running print position after the start decision of this word.
    logic             p_restart;
    logic             p_abort;
    logic [POS_W-1:0] p_pos;
    logic [COL_W-1:0] p_col;
    logic [ROW_W-1:0] p_row;
    logic             p_full;
    logic [COL_W-1:0] p_col_inc;
    logic [ROW_W-1:0] p_row_inc;

    assign p_restart = in_starts && (in_fromcur || in_ok);
    assign p_abort   = in_starts ? !(in_fromcur || in_ok) : abort_reg;
    assign p_pos     = p_restart ? cell_idx : pos_reg;
    assign p_col     = p_restart ? sel_col : pcol_reg;
    assign p_row     = p_restart ? sel_row : prow_reg;
    assign p_full    = p_pos >= POS_END;
    assign p_col_inc = (p_col == COL_LAST) ? '0 : p_col + 1'b1;
    assign p_row_inc = (p_col != COL_LAST) ? p_row :
                       (p_row == ROW_LAST) ? '0 : p_row + 1'b1;

    // Newline row: (row_index + 1) mod ROWS, from a constant table.
    logic [ROW_W-1:0] nl_row_tab [2**ROW_W];

    for (genvar i = 0; i < 2**ROW_W; i++) begin : gen_nl
        localparam int NL_ROW = (i + 1) % ROWS;
        assign nl_row_tab[i] = ROW_W'(NL_ROW);
    end

    // Memory ports.
    logic                 char_we, attr_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [BYTE_W-1:0]    char_wdata, char_rdata;
    logic [ATTR_BITS-1:0] attr_wdata, attr_rdata;

    tcb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_char_ram (
        .aclk (aclk),
        .we   (char_we),
        .waddr(ram_waddr),
        .wdata(char_wdata),
        .re   (ram_re),
        .raddr(cell_idx[ADDR_W-1:0]),
        .rdata(char_rdata)
    );

    tcb_ram #(
        .WIDTH (ATTR_BITS),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_attr_ram (
        .aclk (aclk),
        .we   (attr_we),
        .waddr(ram_waddr),
        .wdata(attr_wdata),
        .re   (ram_re),
        .raddr(cell_idx[ADDR_W-1:0]),
        .rdata(attr_rdata)
    );

    // Result fields of the word being completed.
    logic              load_res;
    logic [BYTE_W-1:0] res_read;
    status_t           res_status;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        pos_next     = pos_reg;
        pcol_next    = pcol_reg;
        prow_next    = prow_reg;
        abort_next   = abort_reg;
        attr_next    = attr_reg;
        rd_char_next = rd_char_reg;
        rd_ok_next   = rd_ok_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        char_we      = 1'b0;
        attr_we      = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = cell_idx[ADDR_W-1:0];
        char_wdata   = in_char;
        attr_wdata   = in_attr;
        load_res     = 1'b0;
        res_read     = '0;
        res_status   = STAT_OK;

        case (state_reg)
            S_CLEAR: begin
                // Zero one cell of each store per cycle.
                char_we    = 1'b1;
                attr_we    = 1'b1;
                ram_waddr  = clr_reg;
                char_wdata = '0;
                attr_wdata = '0;
                if (clr_reg == ADDR_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_READ: begin
                load_res   = 1'b1;
                state_next = S_IDLE;
                if (rd_ok_reg) begin
                    res_read = rd_char_reg ? char_rdata : BYTE_W'(attr_rdata);
                end else begin
                    res_read   = rd_char_reg ? CHAR_OUT_OF_RANGE : '0;
                    res_status = STAT_RANGE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    load_res = 1'b1;
                    case (in_action)
                        ACT_WR_CHAR: begin
                            char_we = in_ok;
                            if (!in_ok) begin
                                res_status = STAT_RANGE;
                            end
                        end
                        ACT_WR_ATTR: begin
                            attr_we = in_ok;
                            if (!in_ok) begin
                                res_status = STAT_RANGE;
                            end
                        end
                        ACT_RD_CHAR, ACT_RD_ATTR: begin
                            // The result is loaded once the memory data is back.
                            load_res     = 1'b0;
                            ram_re       = in_ok;
                            rd_ok_next   = in_ok;
                            rd_char_next = (in_action == ACT_RD_CHAR);
                            state_next   = S_READ;
                        end
                        ACT_SET_CUR: begin
                            if (in_ok) begin
                                cur_col_next = in_col;
                                cur_row_next = in_row;
                            end else begin
                                res_status = STAT_RANGE;
                            end
                        end
                        ACT_PRINT: begin
                            abort_next = p_abort;
                            if (p_restart) begin
                                pos_next  = p_pos;
                                pcol_next = p_col;
                                prow_next = p_row;
                            end
                            if (p_abort) begin
                                res_status = STAT_RANGE;
                            end else if (p_full) begin
                                res_status = STAT_DROPPED;
                            end else begin
                                char_we      = 1'b1;
                                attr_we      = 1'b1;
                                ram_waddr    = p_pos[ADDR_W-1:0];
                                attr_wdata   = attr_reg;
                                pos_next     = p_pos + 1'b1;
                                pcol_next    = p_col_inc;
                                prow_next    = p_row_inc;
                                cur_col_next = p_col_inc;
                                cur_row_next = p_row_inc;
                            end
                        end
                        ACT_NEWLINE: begin
                            cur_col_next = '0;
                            cur_row_next = nl_row_tab[in_row];
                        end
                        ACT_SET_ATTR: begin
                            attr_next = in_attr;
                        end
                        ACT_CLEAR: begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                            pos_next     = '0;
                            pcol_next    = '0;
                            prow_next    = '0;
                            abort_next   = 1'b0;
                            attr_next    = '0;
                            clr_next     = '0;
                            state_next   = S_CLEAR;
                        end
                        default: begin
                            // Unused actions only report the cursor.
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load_res) begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, res_status, cur_row_next, cur_col_next, res_read};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Reset starts with a full clearing sweep of both stores.
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            pos_reg     <= '0;
            pcol_reg    <= '0;
            prow_reg    <= '0;
            abort_reg   <= 1'b0;
            attr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            pos_reg     <= pos_next;
            pcol_reg    <= pcol_next;
            prow_reg    <= prow_next;
            abort_reg   <= abort_next;
            attr_reg    <= attr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_char_reg <= rd_char_next;
        rd_ok_reg   <= rd_ok_next;
        m_data_reg  <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // No word may enter while the stores are being swept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("word accepted during clearing sweep");

    // The cursor always points inside the buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_col_reg < COL_LIM) && (cur_row_reg < ROW_LIM))
        else $error("cursor outside the buffer");

    // The running print position never passes the end of the buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_END)
        else $error("print position beyond buffer end");

    // A word other than a read has its result valid in the cycle after it is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_action != ACT_RD_CHAR) && (in_action != ACT_RD_ATTR))
        |=> m_axis_tvalid)
        else $error("result missing after single-cycle word");

    // A read has its result valid once the memory read and the read state are through.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((in_action == ACT_RD_CHAR) || (in_action == ACT_RD_ATTR)))
        |-> ##2 m_axis_tvalid)
        else $error("result missing after read");
`endif

endmodule

### hdl/tcb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tcb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### verif/text_console_buffer_core_tb.sv
// Self-checking testbench of the text console buffer core, with its own prediction of each result.
`timescale 1ns / 1ps

module text_console_buffer_core_tb;
    import tcb_pkg::*;

    // The geometry under test is the default one of the block.
    localparam int COLS      = DEF_COLUMNS;
    localparam int ROWS_N    = DEF_ROWS;
    localparam int CELLS     = COLS * ROWS_N;
    localparam int ATTR_MASK = (1 << DEF_ATTR_BITS) - 1;

    // One input word, split into its fields.
    typedef struct {
        action_t    action;
        logic [6:0] column;
        logic [4:0] row;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       starts;
        logic       from_cursor;
    } console_cmd_t;

    // One result word. The packed layout matches m_axis_tdata[21:0], so that a
    // result can be taken straight from the bus.
    typedef struct packed {
        status_t    status;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] read_value;
    } console_result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    // Random idling on both sides is allowed while this is set; the final part
    // of the run clears it to stream words back to back.
    bit idle_enable = 1'b1;
    // A nonzero value asks the receiver to hold off for that many cycles.
    int hold_request = 0;

    console_result_t expected_results[$];
    int              mismatch_count = 0;

    // Shadow state of the console, kept up to date as words are accepted.
    logic [7:0] shadow_chars[CELLS];
    logic [7:0] shadow_attrs[CELLS];
    logic [6:0] shadow_cur_col;
    logic [4:0] shadow_cur_row;
    int         shadow_print_pos;
    bit         shadow_print_aborted;
    logic [7:0] shadow_active_attr;

    text_console_buffer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #5 aclk = ~aclk;

    // Puts the shadow state back to its cleared form, as reset and the clear
    // action both do.
    function automatic void clear_shadow();
        foreach (shadow_chars[i]) begin
            shadow_chars[i] = '0;
            shadow_attrs[i] = '0;
        end
        shadow_cur_col       = '0;
        shadow_cur_row       = '0;
        shadow_print_pos     = 0;
        shadow_print_aborted = 1'b0;
        shadow_active_attr   = '0;
    endfunction

    // Prints one character of a string. A starting word picks the start cell,
    // either the cursor or the given coordinates. A start outside the buffer
    // suppresses the rest of the string until the next start. Once the running
    // position has passed the last cell, characters are dropped and the cursor
    // stays put.
    function automatic status_t print_shadow(console_cmd_t cmd, bit in_bounds, int addr);
        if (cmd.starts) begin
            if (cmd.from_cursor) begin
                shadow_print_pos     = int'(shadow_cur_row) * COLS + int'(shadow_cur_col);
                shadow_print_aborted = 1'b0;
            end else if (in_bounds) begin
                shadow_print_pos     = addr;
                shadow_print_aborted = 1'b0;
            end else begin
                shadow_print_aborted = 1'b1;
            end
        end
        if (shadow_print_aborted)
            return STAT_RANGE;
        if (shadow_print_pos >= CELLS)
            return STAT_DROPPED;
        shadow_chars[shadow_print_pos] = cmd.ch;
        shadow_attrs[shadow_print_pos] = shadow_active_attr;
        shadow_print_pos++;
        shadow_cur_col = 7'(shadow_print_pos % COLS);
        shadow_cur_row = 5'((shadow_print_pos / COLS) % ROWS_N);
        return STAT_OK;
    endfunction

    // Applies one accepted word to the shadow state and returns the result
    // that the block has to produce for it.
    function automatic console_result_t predict_console(console_cmd_t cmd);
        console_result_t res;
        bit              in_bounds;
        int              addr;
        res       = '0;
        in_bounds = (int'(cmd.column) < COLS) && (int'(cmd.row) < ROWS_N);
        addr      = in_bounds ? int'(cmd.row) * COLS + int'(cmd.column) : 0;
        case (cmd.action)
            ACT_WR_CHAR: begin
                if (in_bounds) shadow_chars[addr] = cmd.ch;
                else res.status = STAT_RANGE;
            end
            ACT_RD_CHAR: begin
                if (in_bounds) begin
                    res.read_value = shadow_chars[addr];
                end else begin
                    res.read_value = CHAR_OUT_OF_RANGE;
                    res.status     = STAT_RANGE;
                end
            end
            ACT_WR_ATTR: begin
                if (in_bounds) shadow_attrs[addr] = cmd.attr & 8'(ATTR_MASK);
                else res.status = STAT_RANGE;
            end
            ACT_RD_ATTR: begin
                if (in_bounds) res.read_value = shadow_attrs[addr];
                else res.status = STAT_RANGE;
            end
            ACT_SET_CUR: begin
                if (in_bounds) begin
                    shadow_cur_col = cmd.column;
                    shadow_cur_row = cmd.row;
                end else begin
                    res.status = STAT_RANGE;
                end
            end
            ACT_PRINT: res.status = print_shadow(cmd, in_bounds, addr);
            ACT_NEWLINE: begin
                // The newline is never out of range; row 24 and above wrap.
                shadow_cur_col = '0;
                shadow_cur_row = 5'((int'(cmd.row) + 1) % ROWS_N);
            end
            ACT_SET_ATTR: shadow_active_attr = cmd.attr & 8'(ATTR_MASK);
            ACT_CLEAR:    clear_shadow();
            default: ;
        endcase
        res.cursor_col = shadow_cur_col;
        res.cursor_row = shadow_cur_row;
        return res;
    endfunction

    function automatic console_cmd_t cmd_of(action_t act, int col, int row, int ch, int attr,
                                            int starts, int from_cursor);
        console_cmd_t c;
        c.action      = act;
        c.column      = 7'(col);
        c.row         = 5'(row);
        c.ch          = 8'(ch);
        c.attr        = 8'(attr);
        c.starts      = 1'(starts);
        c.from_cursor = 1'(from_cursor);
        return c;
    endfunction

    // Coordinates are mostly inside the buffer, with the edges and the
    // out-of-range values drawn often enough to matter.
    function automatic int rand_column();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return COLS - 1;
            2, 3:    return $urandom_range(COLS, 127);
            default: return $urandom_range(0, COLS - 1);
        endcase
    endfunction

    function automatic int rand_row();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return ROWS_N - 1;
            2, 3:    return $urandom_range(ROWS_N, 31);
            default: return $urandom_range(0, ROWS_N - 1);
        endcase
    endfunction

    // A word of the given action with every other field random; callers
    // override the fields that the sequence needs.
    function automatic console_cmd_t random_cmd(action_t act);
        return cmd_of(act, rand_column(), rand_row(), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    // Offers one word and waits until the block takes it, then records the
    // expected result. It is entered and left at a rising edge, so valid stays
    // high from one word to the next unless a random gap is inserted first.
    task automatic send_word(input console_cmd_t cmd);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= {4'b0000, cmd.attr, cmd.ch, cmd.row, cmd.column};
        s_axis_tuser  <= {cmd.from_cursor, cmd.starts, cmd.action};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        expected_results.push_back(predict_console(cmd));
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Reads and writes of both stores, at the corners and outside the buffer.
    task automatic test_cell_access();
        send_word(cmd_of(ACT_RD_CHAR, 0, 0, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_WR_CHAR, COLS - 1, ROWS_N - 1, 8'hFF, 8'h00, 0, 0));
        send_word(cmd_of(ACT_RD_CHAR, COLS - 1, ROWS_N - 1, 8'h00, 8'hFF, 1, 1));
        send_word(cmd_of(ACT_WR_ATTR, 0, 0, 8'h00, 8'hA5, 0, 0));
        send_word(cmd_of(ACT_RD_ATTR, 0, 0, 8'hFF, 8'h00, 0, 0));
        send_word(cmd_of(ACT_WR_CHAR, COLS, 0, 8'h41, 8'h00, 0, 0));
        send_word(cmd_of(ACT_RD_CHAR, 127, 31, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_RD_ATTR, 0, ROWS_N, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_WR_ATTR, 127, 0, 8'h00, 8'h5A, 0, 0));
    endtask

    // Cursor setting in and out of range, newline from the last row and from beyond the buffer, and an unused action.
    task automatic test_cursor_and_newline();
        send_word(cmd_of(ACT_SET_CUR, 5, 3, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_SET_CUR, COLS, 3, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_NEWLINE, 40, ROWS_N - 1, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_NEWLINE, 127, 31, 8'hFF, 8'hFF, 1, 1));
        send_word(cmd_of(action_t'(4'hF), 127, 31, 8'hFF, 8'hFF, 1, 1));
    endtask

    // Strings that run off the end of the buffer, a start outside it, and a
    // start from the cursor once the last cell has been filled.
    task automatic test_print_strings();
        send_word(cmd_of(ACT_SET_ATTR, 0, 0, 8'h00, 8'hFF, 0, 0));
        send_word(cmd_of(ACT_PRINT, COLS - 2, ROWS_N - 1, 8'h41, 8'h00, 1, 0));
        // A zero character is stored like any other byte.
        send_word(cmd_of(ACT_PRINT, 0, 0, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_PRINT, 0, 0, 8'h42, 8'h00, 0, 0));
        send_word(cmd_of(ACT_PRINT, 100, 2, 8'h43, 8'h00, 1, 0));
        send_word(cmd_of(ACT_PRINT, 0, 0, 8'h44, 8'h00, 0, 1));
        send_word(cmd_of(ACT_PRINT, 127, 31, 8'h78, 8'h00, 1, 1));
    endtask

    // Clear, then a print with no start, which goes to the first cell.
    task automatic test_clear();
        send_word(cmd_of(ACT_CLEAR, 0, 0, 8'h00, 8'h00, 0, 0));
        send_word(cmd_of(ACT_PRINT, 50, 10, 8'h7E, 8'h00, 0, 0));
        send_word(cmd_of(ACT_RD_CHAR, 0, 0, 8'h00, 8'h00, 0, 0));
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so that the output register fills and the block stops
    // taking input.
    task automatic test_backpressure();
        console_cmd_t c;
        hold_request = 300;
        c = random_cmd(ACT_PRINT);
        c.starts      = 1'b1;
        c.from_cursor = 1'b1;
        send_word(c);
        repeat (39) begin
            c = random_cmd(ACT_PRINT);
            c.starts = 1'b0;
            send_word(c);
        end
    endtask

    // Mostly well-formed sequences with random content: strings, writes
    // followed by reads of the same cell, cursor moves followed by printing,
    // plus some noise words and the odd clear.
    task automatic test_random_mix(input int target);
        console_cmd_t c;
        int           sent;
        int           kind;
        int           len;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                c = random_cmd(ACT_PRINT);
                c.starts = 1'b1;
                len      = $urandom_range(1, 12);
                // Some strings start on the last row so they run off the end.
                if ($urandom_range(0, 4) == 0) begin
                    c.column      = 7'($urandom_range(COLS - 20, COLS - 1));
                    c.row         = 5'(ROWS_N - 1);
                    c.from_cursor = 1'b0;
                    len           = 25;
                end
                send_word(c);
                sent++;
                repeat (len) begin
                    c = random_cmd(ACT_PRINT);
                    c.starts = 1'b0;
                    send_word(c);
                    sent++;
                end
            end else if (kind < 55) begin
                c = random_cmd($urandom_range(0, 1) ? ACT_WR_CHAR : ACT_WR_ATTR);
                send_word(c);
                c.action = (c.action == ACT_WR_CHAR) ? ACT_RD_CHAR : ACT_RD_ATTR;
                send_word(c);
                sent += 2;
            end else if (kind < 78) begin
                send_word(random_cmd(kind < 70 ? ACT_SET_CUR : ACT_NEWLINE));
                c = random_cmd(ACT_PRINT);
                c.starts      = 1'b1;
                c.from_cursor = 1'b1;
                send_word(c);
                sent += 2;
                repeat ($urandom_range(0, 6)) begin
                    c = random_cmd(ACT_PRINT);
                    c.starts = 1'b0;
                    send_word(c);
                    sent++;
                end
            end else if (kind < 86) begin
                send_word(random_cmd(ACT_SET_ATTR));
                sent++;
            end else if (kind < 98) begin
                send_word(random_cmd(action_t'($urandom_range(0, 15))));
                sent++;
            end else begin
                send_word(random_cmd(ACT_CLEAR));
                sent++;
            end
        end
    endtask

    // Receiver side: random stall bursts, and the long hold-off when asked.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
                m_axis_tready <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every result word taken by the receiver is compared with the oldest
    // expected result.
    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = console_result_t'(m_axis_tdata[21:0]);
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result word %h arrived with nothing expected", m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.read_value !== want.read_value || got.cursor_col !== want.cursor_col ||
                    got.cursor_row !== want.cursor_row || got.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected read %0d col %0d row %0d status %0d, ",
                                 want.read_value, want.cursor_col, want.cursor_row,
                                 want.status,
                                 "got read %0d col %0d row %0d status %0d",
                                 got.read_value, got.cursor_col, got.cursor_row, got.status);
                end
            end
        end
    end

    // Safety net: the slowest correct run stays well below this.
    initial begin
        #5_000_000;
        $display("text_console_buffer_core_tb failed");
        $finish;
    end

    initial begin
        clear_shadow();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // The block sweeps both stores after reset; the handshake covers it.
        @(posedge aclk);

        test_cell_access();
        test_cursor_and_newline();
        test_print_strings();
        test_clear();
        test_backpressure();
        test_random_mix(590);

        // The last part streams words with no idling on either side.
        idle_enable = 1'b0;
        test_random_mix(100);

        wait_all_results();
        // Leave room for any stray word to show up.
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("text_console_buffer_core_tb passed");
        end else begin
            $display("text_console_buffer_core_tb failed");
        end
        $finish;
    end

endmodule

### files.f
hdl/tcb_pkg.sv
hdl/tcb_ram.sv
hdl/text_console_buffer_core.sv
verif/text_console_buffer_core_tb.sv
